// ----- rtl/gjd_pkg.sv -----
// ----------------------------------------------------------------------------
// gjd_pkg
// Shared types and constants for the Gregorian / Julian day number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gjd_pkg;

  // Number of register stages from input transfer to output register
  localparam int NumStages = 12;

  // Per-stage pipeline control: load enables and occupancy
  typedef struct packed {
    logic [NumStages-1:0] load;
    logic [NumStages-1:0] valid;
  } pipe_ctrl_t;

  // floor(3059 * k / 100): days before a month in the March-based year
  function automatic logic [8:0] month_term(input logic [3:0] k);
    logic [8:0] r;
    case (k)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd152;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd305;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd458;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gjd_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// gjd_pipe_ctrl
// Valid/ready control for the converter pipeline; empty stages collapse so a
// new item enters while a finished result waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_pipe_ctrl import gjd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       out_ready_i,
  output logic            in_ready_o,
  output pipe_ctrl_t      ctrl_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] ready;

  // A stage may load when downstream takes a result or this stage or any later stage is empty
  always_comb begin
    logic [NumStages-1:0] empty;
    empty = ~valid_q;
    for (int k = 0; k < NumStages; k++) begin
      ready[k] = out_ready_i || ((empty >> k) != '0);
    end
  end

  // Occupancy moves one stage per load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (ready[k]) begin
          if (k == 0) begin
            valid_q[k] <= in_valid_i;
          end else begin
            valid_q[k] <= valid_q[k-1];
          end
        end
      end
    end
  end

  assign in_ready_o   = ready[0];
  assign ctrl_o.load  = ready;
  assign ctrl_o.valid = valid_q;

endmodule

`default_nettype wire

// ----- rtl/gregorian_julian_day_converter_core.sv -----
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter_core
// Gregorian date and time <-> Julian day number and seconds of day.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless every stage is full and the
// output side stalls, and returns one result per item, in order, through the
// twelve-stage pipeline: the day-number to date path runs two constant
// divisions by 146097 (each a reciprocal multiply, a multiply-back and a
// correction in successive stages) followed by the month search and the
// February leap clamp, and the seconds split runs two divisions of the same
// form, by 3600 and by 60, in parallel. Stalls on the output side are absorbed
// by empty stages, so input transfers continue until every stage holds an
// item. No state is kept between items; there is no start-up sweep after reset.
// Opcode 0 results carry zeros in the date fields, opcode 1 results carry
// zeros in the day number and seconds-of-day fields.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_julian_day_converter_core import gjd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  //        second[39:34], day_number[62:40], second_of_day[79:63]
  input  wire logic [79:0] s_axis_tdata_i,
  // tuser: opcode[0]
  input  wire logic        s_axis_tuser_i,
  // Output stream
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: out_day_number[22:0], out_second_of_day[39:23], out_year[53:40],
  //        out_month[57:54], out_day[62:58], out_hour[67:63],
  //        out_minute[73:68], out_second[79:74]
  output logic [79:0]      m_axis_tdata_o
);

  localparam int Last = NumStages - 1;

  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [17:0] Period400  = 18'd146097;

  // Fields carried through the stages; each stage fills in its part
  typedef struct packed {
    logic        op;
    // date to day number
    logic        yneg;
    logic [13:0] y0;
    logic [3:0]  mo0;
    logic [4:0]  dday;
    logic [16:0] tod;
    logic [7:0]  q100;
    logic [22:0] jd;
    // day number to date
    logic [23:0] a;
    logic [16:0] sod;
    logic [7:0]  qb;
    logic [18:0] rb;
    logic [7:0]  b;
    logic [15:0] c;
    logic [23:0] x;
    logic [6:0]  qd;
    logic [18:0] rd;
    logic [6:0]  d;
    logic [8:0]  e;
    logic [3:0]  f;
    logic [13:0] yr;
    logic [6:0]  t;
    logic [3:0]  mo;
    logic [4:0]  dd;
    // time of day split
    logic [4:0]  hour;
    logic [12:0] rh;
    logic [11:0] rem;
    logic [5:0]  qm;
    logic [6:0]  rm;
    logic [5:0]  minute;
    logic [5:0]  second;
  } stage_t;

  pipe_ctrl_t ctrl;
  stage_t     st_d [NumStages];
  stage_t     st_q [NumStages];

  gjd_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .ctrl_o      (ctrl)
  );

  // Stage 0: unpack, March-based year shift, seconds sum, day carry on input
  always_comb begin : s0_comb
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [16:0] in_sod;
    logic        lo;
    logic        sod_hi;
    in_year  = s_axis_tdata_i[13:0];
    in_month = s_axis_tdata_i[17:14];
    in_sod   = s_axis_tdata_i[79:63];
    lo       = in_month < 4'd3;
    sod_hi   = in_sod >= SecPerDay;
    st_d[0]      = '0;
    st_d[0].op   = s_axis_tuser_i;
    st_d[0].yneg = lo && (in_year == '0);
    st_d[0].y0   = lo ? in_year - 14'd1 : in_year;
    st_d[0].mo0  = lo ? in_month + 4'd12 : in_month;
    st_d[0].dday = s_axis_tdata_i[22:18];
    st_d[0].tod  = 17'(s_axis_tdata_i[27:23]) * 17'd3600
                 + 17'(s_axis_tdata_i[33:28]) * 17'd60
                 + 17'(s_axis_tdata_i[39:34]);
    st_d[0].sod  = sod_hi ? in_sod - SecPerDay : in_sod;
    st_d[0].a    = 24'(s_axis_tdata_i[62:40]) + 24'd68570 + 24'(sod_hi);
  end

  // Stage 1: year terms, century estimate, 400-year and hour estimates, seconds carry
  always_comb begin : s1_comb
    logic [26:0] prod100;
    logic [32:0] prodb;
    logic [22:0] prodh;
    logic [22:0] yterm;
    logic        tod_hi;
    prod100 = 27'(st_q[0].y0) * 27'd5243;
    prodb   = 33'(st_q[0].a) * 33'd459;
    prodh   = 23'(st_q[0].sod) * 23'd36;
    tod_hi  = st_q[0].tod >= SecPerDay;
    // year zero in Jan/Feb: truncation toward zero gives -365 and no centuries
    yterm   = st_q[0].yneg ? (23'd0 - 23'd365)
                           : 23'(st_q[0].y0) * 23'd365 + 23'(st_q[0].y0[13:2]);
    st_d[1]      = st_q[0];
    st_d[1].q100 = st_q[0].yneg ? 8'd0 : prod100[26:19];
    st_d[1].tod  = tod_hi ? st_q[0].tod - SecPerDay : st_q[0].tod;
    st_d[1].jd   = yterm + 23'(month_term(st_q[0].mo0 - 4'd2)) + 23'd1721088
                 + 23'(st_q[0].dday) + 23'(tod_hi);
    st_d[1].qb   = prodb[31:24];
    st_d[1].hour = prodh[21:17];
  end

  // Stage 2: century correction; remainders of the first estimates
  always_comb begin : s2_comb
    logic [25:0] diffb;
    logic [16:0] diffh;
    diffb = {st_q[1].a, 2'b00} - 26'(st_q[1].qb) * 26'(Period400);
    diffh = st_q[1].sod - 17'(st_q[1].hour) * 17'd3600;
    st_d[2]    = st_q[1];
    st_d[2].jd = st_q[1].jd + 23'(st_q[1].q100[7:2]) - 23'(st_q[1].q100);
    st_d[2].rb = diffb[18:0];
    st_d[2].rh = diffh[12:0];
  end

  // Stage 3: fix up 400-year count and hour; day within the 400-year period
  always_comb begin : s3_comb
    logic        gb;
    logic        gh;
    logic [18:0] rr;
    logic [12:0] rh;
    gb = st_q[2].rb >= 19'(Period400);
    gh = st_q[2].rh >= 13'd3600;
    rr = gb ? st_q[2].rb - 19'(Period400) : st_q[2].rb;
    rh = gh ? st_q[2].rh - 13'd3600 : st_q[2].rh;
    st_d[3]      = st_q[2];
    st_d[3].b    = st_q[2].qb + 8'(gb);
    st_d[3].c    = rr[17:2];
    st_d[3].hour = st_q[2].hour + 5'(gh);
    st_d[3].rem  = rh[11:0];
  end

  // Stage 4: scale day for the year count; minute estimate
  always_comb begin : s4_comb
    logic [18:0] prodm;
    prodm = 19'(st_q[3].rem) * 19'd68;
    st_d[4]    = st_q[3];
    st_d[4].x  = (24'(st_q[3].c) + 24'd1) * 24'd400;
    st_d[4].qm = prodm[17:12];
  end

  // Stage 5: year-in-period estimate; minute remainder
  always_comb begin : s5_comb
    logic [30:0] prodd;
    logic [11:0] diffm;
    prodd = 31'(st_q[4].x) * 31'd114;
    diffm = st_q[4].rem - 12'(st_q[4].qm) * 12'd60;
    st_d[5]    = st_q[4];
    st_d[5].qd = prodd[30:24];
    st_d[5].rm = diffm[6:0];
  end

  // Stage 6: year remainder; minute and second fix-up
  always_comb begin : s6_comb
    logic [23:0] diffd;
    logic        gm;
    logic [6:0]  rm;
    diffd = st_q[5].x - 24'(st_q[5].qd) * 24'(Period400);
    gm    = st_q[5].rm >= 7'd60;
    rm    = gm ? st_q[5].rm - 7'd60 : st_q[5].rm;
    st_d[6]        = st_q[5];
    st_d[6].rd     = diffd[18:0];
    st_d[6].minute = st_q[5].qm + 6'(gm);
    st_d[6].second = rm[5:0];
  end

  // Stage 7: year-in-period correction
  always_comb begin : s7_comb
    st_d[7]   = st_q[6];
    st_d[7].d = st_q[6].qd + 7'(st_q[6].rd >= 19'(Period400));
  end

  // Stage 8: day within the March-based year, offset by 31
  always_comb begin : s8_comb
    logic [16:0] ediff;
    ediff = 17'(st_q[7].c) + 17'd31 - 17'(st_q[7].d) * 17'd365
          - 17'(st_q[7].d[6:2]);
    st_d[8]   = st_q[7];
    st_d[8].e = ediff[8:0];
  end

  // Stage 9: month index by threshold compare; century part of the year
  always_comb begin : s9_comb
    logic [12:0] th;
    for (int k = 1; k <= 13; k++) begin
      th[k-1] = st_q[8].e > month_term(4'(k));
    end
    st_d[9]    = st_q[8];
    st_d[9].f  = 4'($countones(th));
    st_d[9].yr = 14'(st_q[8].b) * 14'd100 - 14'd4900;
  end

  // Stage 10: month, day of month, year with Jan/Feb roll-over
  always_comb begin : s10_comb
    logic       g;
    logic [8:0] ddiff;
    g     = st_q[9].f >= 4'd11;
    ddiff = st_q[9].e - month_term(st_q[9].f);
    st_d[10]    = st_q[9];
    st_d[10].mo = st_q[9].f - (g ? 4'd12 : 4'd0) + 4'd2;
    st_d[10].dd = ddiff[4:0];
    st_d[10].t  = st_q[9].d + 7'(g);
    st_d[10].yr = st_q[9].yr + 14'(st_q[9].d) + 14'(g);
  end

  // Stage 11: leap test on the full year value and February clamp
  always_comb begin : s11_comb
    logic       hi;
    logic [6:0] tp;
    logic [1:0] cent4;
    logic       leap;
    // year = 100 * (b - 49 + hi) + tp with tp below 100
    hi    = st_q[10].t >= 7'd100;
    tp    = hi ? st_q[10].t - 7'd100 : st_q[10].t;
    cent4 = st_q[10].b[1:0] + 2'd3 + 2'(hi);
    leap  = (tp != '0) ? (tp[1:0] == 2'd0) : (cent4 == 2'd0);
    st_d[11] = st_q[10];
    if (st_q[10].mo == 4'd2 && st_q[10].dd > 5'd28) begin
      st_d[11].dd = leap ? 5'd29 : 5'd28;
    end
  end

  // Stage registers load whenever the stage may advance
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumStages; k++) begin
      if (ctrl.load[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Output packing; fields of the other opcode read as zero
  assign m_axis_tvalid_o        = ctrl.valid[Last];
  assign m_axis_tdata_o[22:0]   = st_q[Last].op ? 23'd0 : st_q[Last].jd;
  assign m_axis_tdata_o[39:23]  = st_q[Last].op ? 17'd0 : st_q[Last].tod;
  assign m_axis_tdata_o[53:40]  = st_q[Last].op ? st_q[Last].yr : 14'd0;
  assign m_axis_tdata_o[57:54]  = st_q[Last].op ? st_q[Last].mo : 4'd0;
  assign m_axis_tdata_o[62:58]  = st_q[Last].op ? st_q[Last].dd : 5'd0;
  assign m_axis_tdata_o[67:63]  = st_q[Last].op ? st_q[Last].hour : 5'd0;
  assign m_axis_tdata_o[73:68]  = st_q[Last].op ? st_q[Last].minute : 6'd0;
  assign m_axis_tdata_o[79:74]  = st_q[Last].op ? st_q[Last].second : 6'd0;

  // Input back-pressure only when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ((&ctrl.valid) && !m_axis_tready_i))
    else $error("input stalled with a free pipeline stage");

  // Month search lands in a real month
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid[Last] && st_q[Last].op) |->
      (st_q[Last].mo >= 4'd1 && st_q[Last].mo <= 4'd12))
    else $error("computed month out of range");

  // February clamp applied
  a_feb_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid[Last] && st_q[Last].op && st_q[Last].mo == 4'd2) |->
      (st_q[Last].dd <= 5'd29))
    else $error("February day above 29");

  // Seconds of day reduced below one day after the carry stage
  a_tod_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid[1] && !st_q[1].op) |-> (st_q[1].tod < SecPerDay))
    else $error("seconds of day not reduced");

endmodule

`default_nettype wire
